// ===== hw/rtl/lpsc_pkg.sv =====
package lpsc_pkg;

	localparam int SLOT_COUNT = 512;
	localparam int GRID_SIZE  = 128;
	localparam int MAX_SPAN   = 8;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int COORD_W    = $clog2(GRID_SIZE);
	localparam int AGE_W      = 64;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_INVAL = 2'd1;
	localparam logic [1:0] ACT_FILL  = 2'd2;

	localparam logic [2:0] ST_HIT    = 3'd0;
	localparam logic [2:0] ST_RETIER = 3'd1;
	localparam logic [2:0] ST_MISS   = 3'd2;
	localparam logic [2:0] ST_DROP   = 3'd3;
	localparam logic [2:0] ST_RANGE  = 3'd4;
	localparam logic [2:0] ST_FRAME  = 3'd5;

	typedef struct packed {
		logic                used;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  z;
		logic [3:0]          span;
		logic [2:0]          tier;
	} tag_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HSCAN,
		S_HCHK,
		S_DECIDE,
		S_FSCAN,
		S_VSCAN,
		S_VTAG,
		S_VEMIT,
		S_FILL,
		S_OUT
	} state_t;

endpackage

// ===== hw/rtl/lru_page_slot_cache_core.sv =====
// Page-slot cache, fully associative, LRU replacement.
// Input channel (in_valid/in_ready) carries one request: mode, fine_x, fine_z,
// span, tier. Output channel (out_valid/out_ready) carries one or two result
// transactions per request; last marks the final one. The user must write
// the per-frame budget through fill_budget_we/fill_budget_wd only while the
// block is idle; the block does not enforce this. Tags and ages live in two
// one-port-read synchronous memories (512 deep). End of frame and out-of-range
// results are registered on acceptance and appear in the cycle after it; the
// block takes no new request until such a result drains. A page request scans
// all slots for a tag match before its hit or drop result is registered. A
// miss adds a free-slot scan and, when full, an age scan for the victim, each
// one slot per cycle; the serial memory scans set the time to the fill result.
// Reset (arst_n low) clears control state and starts a clearing pass over
// the tag and age memories, during which in_ready stays low.
// A stalled receiver holds the result register; the block accepts no new
// request until the result transactions drain and holds back its next result.
module lru_page_slot_cache_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fill_budget_we,
	input  logic [4:0]  fill_budget_wd,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [8:0]  fine_x,
	input  logic [8:0]  fine_z,
	input  logic [3:0]  span,
	input  logic [2:0]  tier,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [6:0]  region_x,
	output logic [6:0]  region_z,
	output logic [3:0]  region_span,
	output logic [2:0]  fill_tier,
	output logic [8:0]  slot,
	output logic [2:0]  status,
	output logic        last,
	output logic [9:0]  resident,
	output logic [31:0] evictions
);
	import lpsc_pkg::*;

	tag_t             tag_mem [SLOT_COUNT];
	logic [AGE_W-1:0] age_mem [SLOT_COUNT];

	// memory ports
	logic              tag_we, age_we;
	logic [SLOT_W-1:0] tag_wa, age_wa, rd_a;
	tag_t              tag_wd;
	logic [AGE_W-1:0]  age_wd;
	tag_t              tag_rd;
	logic [AGE_W-1:0]  age_rd;

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_wa] <= tag_wd;
		if (age_we) age_mem[age_wa] <= age_wd;
		tag_rd <= tag_mem[rd_a];
		age_rd <= age_mem[rd_a];
	end

	// control state
	state_t            state_q, state_d;
	logic              clr_q;
	logic [SLOT_W:0]   idx_q, idx_d;      // address issued, one wider for end test
	logic [SLOT_W-1:0] chk_q, chk_d;      // address of data now on tag_rd
	logic              rdv_q, rdv_d;      // tag_rd holds a scanned entry
	logic [4:0]        budget_q, fills_q, fills_d, invs_q, invs_d;
	logic [AGE_W-1:0]  touch_q, touch_d;
	logic [CNT_W-1:0]  res_q, res_d;
	logic [31:0]       evc_q, evc_d;

	// request and scan registers
	logic [COORD_W-1:0] rx_q, rz_q;
	logic [3:0]         rspan_q;
	logic [2:0]         rtier_q;
	logic               hit_q, hit_d;
	logic [SLOT_W-1:0]  hslot_q, hslot_d;
	tag_t               htag_q, htag_d;
	logic               free_q, free_d;
	logic [SLOT_W-1:0]  vslot_q, vslot_d;
	logic [AGE_W-1:0]   vage_q, vage_d;
	logic               two_q, two_d;     // an invalidate precedes the fill

	// result register
	logic        ov_q, ov_d;
	logic [1:0]  act_q, act_d;
	logic [6:0]  ox_q, ox_d, oz_q, oz_d;
	logic [3:0]  osp_q, osp_d;
	logic [2:0]  otr_q, otr_d, ost_q, ost_d;
	logic [8:0]  osl_q, osl_d;
	logic        olast_q, olast_d;

	logic in_ok, in_range, out_free;

	assign in_ok    = in_valid && in_ready;
	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && !clr_q && !ov_q;
	assign in_range = !fine_x[8] && !fine_z[8]
		&& ({1'b0, fine_x[7:0]} < 9'(GRID_SIZE))
		&& ({1'b0, fine_z[7:0]} < 9'(GRID_SIZE))
		&& (span != 4'd0) && ({1'b0, span} <= 5'(MAX_SPAN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			clr_q    <= 1'b1;
			idx_q    <= '0;
			chk_q    <= '0;
			rdv_q    <= 1'b0;
			budget_q <= 5'd16;
			fills_q  <= '0;
			invs_q   <= '0;
			touch_q  <= '0;
			res_q    <= '0;
			evc_q    <= '0;
			ov_q     <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			two_q    <= 1'b0;
		end else begin
			if (fill_budget_we) budget_q <= fill_budget_wd;
			if (clr_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q[SLOT_W-1:0] == SLOT_W'(SLOT_COUNT - 1)) begin
					clr_q <= 1'b0;
					idx_q <= '0;
				end
			end else begin
				idx_q <= idx_d;
			end
			state_q <= state_d;
			chk_q   <= chk_d;
			rdv_q   <= rdv_d;
			fills_q <= fills_d;
			invs_q  <= invs_d;
			touch_q <= touch_d;
			res_q   <= res_d;
			evc_q   <= evc_d;
			ov_q    <= ov_d;
			hit_q   <= hit_d;
			free_q  <= free_d;
			two_q   <= two_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ok) begin
			rx_q    <= fine_x[COORD_W-1:0];
			rz_q    <= fine_z[COORD_W-1:0];
			rspan_q <= span;
			rtier_q <= tier;
		end
		hslot_q <= hslot_d;
		htag_q  <= htag_d;
		vslot_q <= vslot_d;
		vage_q  <= vage_d;
		act_q   <= act_d;
		ox_q    <= ox_d;
		oz_q    <= oz_d;
		osp_q   <= osp_d;
		otr_q   <= otr_d;
		ost_q   <= ost_d;
		osl_q   <= osl_d;
		olast_q <= olast_d;
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		chk_d   = idx_q[SLOT_W-1:0];
		rdv_d   = 1'b0;
		fills_d = fills_q;
		invs_d  = invs_q;
		touch_d = touch_q;
		res_d   = res_q;
		evc_d   = evc_q;
		hit_d   = hit_q;
		hslot_d = hslot_q;
		htag_d  = htag_q;
		free_d  = free_q;
		vslot_d = vslot_q;
		vage_d  = vage_q;
		two_d   = two_q;
		ov_d    = ov_q && !out_ready;
		act_d   = act_q;
		ox_d    = ox_q;
		oz_d    = oz_q;
		osp_d   = osp_q;
		otr_d   = otr_q;
		ost_d   = ost_q;
		osl_d   = osl_q;
		olast_d = olast_q;
		tag_we  = 1'b0;
		tag_wa  = idx_q[SLOT_W-1:0];
		tag_wd  = '0;
		age_we  = 1'b0;
		age_wa  = idx_q[SLOT_W-1:0];
		age_wd  = '0;
		rd_a    = idx_q[SLOT_W-1:0];

		if (clr_q) begin
			// wipe one tag and age per cycle after reset
			tag_we = 1'b1;
			age_we = 1'b1;
		end

		unique case (state_q)
			S_IDLE: begin
				idx_d = '0;
				if (in_ok) begin
					ov_d    = 1'b1;
					act_d   = ACT_NONE;
					ox_d    = '0;
					oz_d    = '0;
					osp_d   = '0;
					otr_d   = '0;
					osl_d   = '0;
					olast_d = 1'b1;
					if (mode) begin
						fills_d = '0;
						invs_d  = '0;
						ost_d   = ST_FRAME;
					end else if (!in_range) begin
						ost_d   = ST_RANGE;
					end else begin
						ov_d    = 1'b0;
						hit_d   = 1'b0;
						state_d = S_HSCAN;
					end
				end
			end
			S_HSCAN: begin
				// issue reads for every slot; compare each in the cycle after its read
				if (rdv_q && !hit_q && tag_rd.used && tag_rd.x == rx_q && tag_rd.z == rz_q) begin
					hit_d   = 1'b1;
					hslot_d = chk_q;
					htag_d  = tag_rd;
				end
				if (idx_q == (SLOT_W+1)'(SLOT_COUNT)) begin
					state_d = S_HCHK;
				end else begin
					rdv_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			S_HCHK: begin
				if (rdv_q && !hit_q && tag_rd.used && tag_rd.x == rx_q && tag_rd.z == rz_q) begin
					hit_d   = 1'b1;
					hslot_d = chk_q;
					htag_d  = tag_rd;
				end
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (out_free) begin
					ov_d    = 1'b1;
					act_d   = ACT_NONE;
					ox_d    = '0;
					oz_d    = '0;
					osp_d   = '0;
					otr_d   = '0;
					osl_d   = '0;
					olast_d = 1'b1;
					state_d = S_IDLE;
					if (hit_q && htag_q.span == rspan_q) begin
						touch_d = touch_q + 1'b1;
						age_we  = 1'b1;
						age_wa  = hslot_q;
						age_wd  = touch_q + 1'b1;
						if (htag_q.tier == rtier_q) begin
							ost_d = ST_HIT;
						end else if (fills_q >= budget_q) begin
							ost_d = ST_DROP;
						end else begin
							tag_we  = 1'b1;
							tag_wa  = hslot_q;
							tag_wd  = htag_q;
							tag_wd.tier = rtier_q;
							fills_d = fills_q + 1'b1;
							act_d   = ACT_FILL;
							ox_d    = 7'(rx_q);
							oz_d    = 7'(rz_q);
							osp_d   = rspan_q;
							otr_d   = rtier_q;
							osl_d   = 9'(hslot_q);
							ost_d   = ST_RETIER;
						end
					end else if (fills_q >= budget_q || invs_q >= budget_q) begin
						ost_d = ST_DROP;
					end else begin
						ost_d = ST_MISS;
						two_d = hit_q;
						if (hit_q) begin
							// free the old footprint, report it first; the slot
							// count nets out once the fill lands in a free slot
							tag_we  = 1'b1;
							tag_wa  = hslot_q;
							tag_wd  = htag_q;
							tag_wd.used = 1'b0;
							invs_d  = invs_q + 1'b1;
							act_d   = ACT_INVAL;
							ox_d    = 7'(htag_q.x);
							oz_d    = 7'(htag_q.z);
							osp_d   = htag_q.span;
							osl_d   = 9'(hslot_q);
							olast_d = 1'b0;
						end else begin
							ov_d = 1'b0;
						end
						free_d  = 1'b0;
						idx_d   = '0;
						state_d = S_FSCAN;
					end
				end
			end
			S_FSCAN: begin
				// lowest unused slot
				if (rdv_q && !free_q && !tag_rd.used) begin
					free_d  = 1'b1;
					vslot_d = chk_q;
				end
				if (idx_q == (SLOT_W+1)'(SLOT_COUNT) && !rdv_q) begin
					idx_d   = '0;
					if (free_q) state_d = S_FILL;
					else        state_d = S_VSCAN;
					vslot_d = free_q ? vslot_q : '0;
					vage_d  = free_q ? vage_q : '1;
				end else if (idx_q != (SLOT_W+1)'(SLOT_COUNT)) begin
					rdv_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			S_VSCAN: begin
				// smallest age, lowest index wins ties
				if (rdv_q && (age_rd < vage_q || (chk_q == '0))) begin
					vage_d  = age_rd;
					vslot_d = chk_q;
				end
				if (idx_q == (SLOT_W+1)'(SLOT_COUNT) && !rdv_q) begin
					state_d = S_VTAG;
				end else if (idx_q != (SLOT_W+1)'(SLOT_COUNT)) begin
					rdv_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			S_VTAG: begin
				rd_a    = vslot_q;
				state_d = S_VEMIT;
			end
			S_VEMIT: begin
				rd_a = vslot_q;
				if (!ov_q) begin
					ov_d    = 1'b1;
					evc_d   = evc_q + 1'b1;
					invs_d  = invs_q + 1'b1;
					act_d   = ACT_INVAL;
					ox_d    = 7'(tag_rd.x);
					oz_d    = 7'(tag_rd.z);
					osp_d   = tag_rd.span;
					otr_d   = '0;
					osl_d   = 9'(vslot_q);
					ost_d   = ST_MISS;
					olast_d = 1'b0;
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				if (out_free) begin
					tag_we       = 1'b1;
					tag_wa       = vslot_q;
					tag_wd.used  = 1'b1;
					tag_wd.x     = rx_q;
					tag_wd.z     = rz_q;
					tag_wd.span  = rspan_q;
					tag_wd.tier  = rtier_q;
					age_we       = 1'b1;
					age_wa       = vslot_q;
					age_wd       = touch_q + 1'b1;
					touch_d      = touch_q + 1'b1;
					fills_d      = fills_q + 1'b1;
					if (free_q && !two_q) res_d = res_q + 1'b1;
					ov_d    = 1'b1;
					act_d   = ACT_FILL;
					ox_d    = 7'(rx_q);
					oz_d    = 7'(rz_q);
					osp_d   = rspan_q;
					otr_d   = rtier_q;
					osl_d   = 9'(vslot_q);
					ost_d   = ST_MISS;
					olast_d = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid   = ov_q;
	assign action      = act_q;
	assign region_x    = ox_q;
	assign region_z    = oz_q;
	assign region_span = osp_q;
	assign fill_tier   = otr_q;
	assign slot        = osl_q;
	assign status      = ost_q;
	assign last        = olast_q;
	assign resident    = 10'(res_q);
	assign evictions   = evc_q;
endmodule

// ===== hw/rtl/lpsc_checker.sv =====
module lpsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] action,
	input logic [2:0] status,
	input logic       last
);
	import lpsc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");
	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_INVAL |-> !last) else $error("invalidate marked last");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_NONE |-> last && status != ST_MISS)
		else $error("empty result malformed");
endmodule

bind lru_page_slot_cache_core lpsc_checker u_lpsc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .action(action),
	.status(status), .last(last)
);
